FILE: design/rkq_pkg.sv
// ----------------------------------------------------------------------------
// rkq_pkg
// shared types and constants for the range k-th smallest query block
// ----------------------------------------------------------------------------
package rkq_pkg;

  localparam int DEPTH = 256;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] WIN_FIRST  = 2'd0;
  localparam logic [1:0] WIN_SECOND = 2'd1;
  localparam logic [1:0] WIN_TIE    = 2'd2;

  localparam logic [1:0] REG_ELEMENT_COUNT = 2'd0;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  load_index;
    logic [31:0] load_value;
    logic [8:0]  range_left;
    logic [8:0]  range_right;
    logic [8:0]  rank_k;
    logic [15:0] guess_first;
    logic [15:0] guess_second;
  } req_t;

  typedef struct packed {
    logic [31:0] kth_value;
    logic [8:0]  match_count;
    logic [1:0]  winner;
    logic        query_error;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic start;
    logic outer_rd;
    logic cand_load;
    logic inner_rd;
    logic inner_acc;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic bad;
    logic inner_last;
    logic outer_last;
    logic found;
  } sts_t;

endpackage

FILE: design/rkq_if.sv
// ----------------------------------------------------------------------------
// rkq_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface rkq_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/range_kth_smallest_query.sv
// a query over a range of n entries runs up to n candidate counting passes,
// each: read candidate, load it, scan the range, drain, check; a rejected
// query gives its result in the cycle after acceptance, a load is written
// on acceptance; one item at a time
// reset: synchronous, clears control and sets element_count to 256;
// store contents are undefined until loaded
// ----------------------------------------------------------------------------
// range_kth_smallest_query
// top level: apb register, sequencer and datapath
// ----------------------------------------------------------------------------
module range_kth_smallest_query import rkq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rkq_if.sink         req,
  rkq_if.source       rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  ctl_t       ctl;
  sts_t       sts;
  logic [8:0] element_count;

  assign pready = 1'b1;
  assign prdata = (paddr == {REG_ELEMENT_COUNT}) ? {23'd0, element_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= 9'd256;
    end else if (psel && penable && pwrite && paddr == REG_ELEMENT_COUNT) begin
      element_count <= pwdata[8:0];
    end
  end

  rkq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_cmd    (req.data.cmd),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  rkq_datapath u_dp (
    .clk           (clk),
    .ctl           (ctl),
    .sts           (sts),
    .req           (req.data),
    .element_count (element_count),
    .rsp           (rsp.data)
  );
endmodule

FILE: design/rkq_ram.sv
// ----------------------------------------------------------------------------
// rkq_ram
// single write port, single registered read port
// ----------------------------------------------------------------------------
module rkq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/rkq_datapath.sv
// ----------------------------------------------------------------------------
// rkq_datapath
// store, candidate and scan registers, compare and count logic
// ----------------------------------------------------------------------------
module rkq_datapath import rkq_pkg::*; (
  input  logic        clk,
  input  ctl_t        ctl,
  output sts_t        sts,
  input  req_t        req,
  input  logic [8:0]  element_count,
  output rsp_t        rsp
);
  logic [CW-1:0] limit;
  logic [CW-1:0] lo, len;
  logic [CW-1:0] k;
  logic [15:0]   g1, g2;
  logic [CW-1:0] oi, ij;
  logic [CW-1:0] less, eq;
  logic [31:0]   cand;
  logic          inner_v;
  logic [31:0]   rdata;
  logic [AW-1:0] raddr;
  logic          bad;
  logic [15:0]   d1, d2;
  logic [15:0]   cnt16;

  assign limit = (element_count > 9'(DEPTH)) ? CW'(DEPTH) : CW'(element_count);
  assign bad = (req.range_left == 9'd0) || (req.range_right < req.range_left)
    || (CW'(req.range_right) > limit) || (req.rank_k == 9'd0)
    || (req.rank_k > 9'(req.range_right - req.range_left + 9'd1));
  assign sts.bad = bad;

  assign raddr = ctl.outer_rd ? AW'(lo + oi - CW'(1)) : AW'(lo + ij - CW'(1));

  rkq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ctl.load),
    .waddr (AW'(req.load_index)),
    .wdata (req.load_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sts.inner_last = (ij == len);
  assign sts.outer_last = (oi == len);
  assign sts.found = (less < k) && (k <= less + eq);

  assign cnt16 = 16'(eq);
  assign d1 = (g1 >= cnt16) ? g1 - cnt16 : cnt16 - g1;
  assign d2 = (g2 >= cnt16) ? g2 - cnt16 : cnt16 - g2;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      lo  <= CW'(req.range_left);
      len <= CW'(req.range_right - req.range_left + 9'd1);
      k   <= CW'(req.rank_k);
      g1  <= req.guess_first;
      g2  <= req.guess_second;
      oi  <= '0;
    end
    if (ctl.outer_rd) begin
      oi <= oi + CW'(1);
    end
    if (ctl.cand_load) begin
      cand    <= rdata;
      less    <= '0;
      eq      <= '0;
      ij      <= '0;
    end
    if (ctl.inner_rd) begin
      ij <= ij + CW'(1);
    end
    inner_v <= ctl.inner_rd;
    if (ctl.inner_acc && inner_v) begin
      if (rdata == cand) begin
        eq <= eq + CW'(1);
      end else if ($signed(rdata) < $signed(cand)) begin
        less <= less + CW'(1);
      end
    end
    if (ctl.finish) begin
      if (bad && ctl.start) begin
        rsp <= '{kth_value: '0, match_count: '0, winner: WIN_FIRST, query_error: 1'b1};
      end else begin
        rsp.kth_value   <= cand;
        rsp.match_count <= 9'(eq);
        rsp.winner      <= (d1 < d2) ? WIN_FIRST : ((d2 < d1) ? WIN_SECOND : WIN_TIE);
        rsp.query_error <= 1'b0;
      end
    end
  end
endmodule

FILE: design/rkq_ctrl.sv
// ----------------------------------------------------------------------------
// rkq_ctrl
// sequencer: outer candidate loop, inner counting pass, output handshake
// ----------------------------------------------------------------------------
module rkq_ctrl import rkq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output ctl_t ctl,
  input  sts_t sts
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ORD   = 6'b000010,
    S_CAND  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_CHECK = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   take;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign take = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    ctl            = '0;
    case (state)
      S_IDLE: begin
        if (take) begin
          if (in_cmd == CMD_LOAD) begin
            ctl.load = 1'b1;
          end else begin
            ctl.start = 1'b1;
            if (sts.bad) begin
              ctl.finish     = 1'b1;
              out_valid_next = 1'b1;
            end else begin
              state_next = S_ORD;
            end
          end
        end
      end
      S_ORD: begin
        ctl.outer_rd = 1'b1;
        state_next   = S_CAND;
      end
      S_CAND: begin
        ctl.cand_load = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        ctl.inner_acc = 1'b1;
        if (sts.inner_last) begin
          state_next = S_DRAIN;
        end else begin
          ctl.inner_rd = 1'b1;
        end
      end
      S_DRAIN: begin
        ctl.inner_acc = 1'b1;
        state_next    = S_CHECK;
      end
      S_CHECK: begin
        if (sts.found || sts.outer_last) begin
          ctl.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end else begin
          state_next = S_ORD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

FILE: tb/rkq_tb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rkq_tb_if
// package rkq_tb_pkg with the bench depth; the testbench reuses the design's valid/ready channel rkq_if
// ----------------------------------------------------------------------------
package rkq_tb_pkg;
  localparam int TB_DEPTH = 256;
endpackage

FILE: tb/range_kth_smallest_query_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_kth_smallest_query_tb
// loads the value store, sets element_count through apb and sends directed
// and random queries; each answer is predicted in the bench and checked
// field by field, under varying sender and receiver stalls
// ----------------------------------------------------------------------------
module range_kth_smallest_query_tb;
  import rkq_pkg::*;
  import rkq_tb_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rkq_if #(.T(req_t)) req_ch ();
  rkq_if #(.T(rsp_t)) rsp_ch ();

  range_kth_smallest_query i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch.sink),
    .rsp     (rsp_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [31:0] store_copy [TB_DEPTH];
  logic [8:0]  element_limit;
  rsp_t        answers_due [$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          value_pool [6] = '{0, -1, 7, 32'h7fffffff, 32'h80000000, 100};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic rsp_t rank_query(req_t r);
    rsp_t a;
    int   limit;
    int   len;
    int   less;
    int   same;
    int   d1;
    int   d2;
    a = '0;
    limit = (element_limit > TB_DEPTH) ? TB_DEPTH : element_limit;
    if (r.range_left == 0 || r.range_right < r.range_left || r.range_right > limit ||
        r.rank_k == 0 || r.rank_k > r.range_right - r.range_left + 1) begin
      a.query_error = 1'b1;
      return a;
    end
    len = r.range_right - r.range_left + 1;
    for (int i = 0; i < len; i++) begin
      less = 0;
      same = 0;
      for (int j = 0; j < len; j++) begin
        if (store_copy[r.range_left - 1 + j] == store_copy[r.range_left - 1 + i])
          same++;
        else if ($signed(store_copy[r.range_left - 1 + j]) <
                 $signed(store_copy[r.range_left - 1 + i]))
          less++;
      end
      if (less < r.rank_k && r.rank_k <= less + same) begin
        a.kth_value = store_copy[r.range_left - 1 + i];
        a.match_count = 9'(same);
        break;
      end
    end
    d1 = r.guess_first > a.match_count ? r.guess_first - a.match_count
                                       : a.match_count - r.guess_first;
    d2 = r.guess_second > a.match_count ? r.guess_second - a.match_count
                                        : a.match_count - r.guess_second;
    a.winner = d1 < d2 ? WIN_FIRST : (d2 < d1 ? WIN_SECOND : WIN_TIE);
    return a;
  endfunction

  task automatic send_item(req_t r);
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    if (r.cmd == CMD_LOAD)
      store_copy[r.load_index] = r.load_value;
    else
      answers_due.push_back(rank_query(r));
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_element_count(logic [8:0] value);
    wait_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'(REG_ELEMENT_COUNT * 4);
    pwdata  <= {23'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    element_limit = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic req_t load_of(int idx, logic [31:0] value);
    req_t r;
    r = req_t'({$urandom, $urandom, $urandom});
    r.cmd = CMD_LOAD;
    r.load_index = 8'(idx);
    r.load_value = value;
    return r;
  endfunction

  function automatic req_t query_of(int lo, int hi, int k, int g1, int g2);
    req_t r;
    r = req_t'({$urandom, $urandom, $urandom});
    r.cmd = CMD_QUERY;
    r.range_left = 9'(lo);
    r.range_right = 9'(hi);
    r.rank_k = 9'(k);
    r.guess_first = 16'(g1);
    r.guess_second = 16'(g2);
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(2))
      0: return $urandom;
      default: return value_pool[$urandom_range(5)];
    endcase
  endfunction

  function automatic req_t random_query();
    int limit;
    int len;
    int lo;
    int hi;
    int g1;
    int g2;
    limit = (element_limit > TB_DEPTH) ? TB_DEPTH : element_limit;
    if ($urandom_range(199) == 0)
      len = limit;
    else if ($urandom_range(9) == 0)
      len = $urandom_range(limit < 64 ? limit : 64, 1);
    else
      len = $urandom_range(limit < 16 ? limit : 16, 1);
    lo = $urandom_range(limit - len + 1, 1);
    hi = lo + len - 1;
    g1 = $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(20);
    g2 = $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(20);
    if ($urandom_range(9) != 0)
      return query_of(lo, hi, $urandom_range(len, 1), g1, g2);
    case ($urandom_range(4))
      0: return query_of(0, $urandom_range(511), $urandom_range(511), g1, g2);
      1: begin
        lo = $urandom_range(511, 2);
        return query_of(lo, $urandom_range(lo - 1, 1), $urandom_range(511), g1, g2);
      end
      2: begin
        hi = $urandom_range(511, limit + 1);
        return query_of($urandom_range(hi, 1), hi, $urandom_range(511), g1, g2);
      end
      3: return query_of(lo, hi, 0, g1, g2);
      default: return query_of(lo, hi, $urandom_range(511, len + 1), g1, g2);
    endcase
  endfunction

  // every entry gets written before any query can read it
  task automatic test_preload();
    for (int i = 0; i < TB_DEPTH; i++)
      send_item(load_of(i, i < 8 ? value_pool[i % 6] : pick_value()));
  endtask

  task automatic test_directed();
    send_item(load_of(0, 32'h80000000));
    send_item(load_of(1, 32'h7fffffff));
    send_item(load_of(2, 32'h7fffffff));
    send_item(load_of(255, 32'hffffffff));
    send_item(query_of(1, 3, 1, 0, 65535));
    send_item(query_of(1, 3, 3, 65535, 2));
    send_item(query_of(2, 3, 2, 1, 3));
    send_item(query_of(255, 256, 2, 0, 0));
    send_item(query_of(1, 256, 256, 65535, 0));
    send_item(query_of(1, 256, 1, 7, 9));
    send_item(query_of(0, 3, 1, 0, 0));
    send_item(query_of(3, 2, 1, 0, 0));
    send_item(query_of(1, 257, 1, 0, 0));
    send_item(query_of(1, 3, 0, 0, 0));
    send_item(query_of(1, 3, 4, 0, 0));
    send_item(query_of(511, 511, 511, 65535, 65535));
    write_element_count(9'd1);
    send_item(query_of(1, 1, 1, 1, 0));
    send_item(query_of(1, 2, 1, 1, 0));
    write_element_count(9'd511);
    send_item(query_of(1, 256, 128, 3, 4));
    send_item(query_of(1, 257, 1, 0, 0));
  endtask

  task automatic test_random(int count, int s_idle, int r_stall, logic [8:0] limit);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    write_element_count(limit);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) < 3)
        send_item(load_of($urandom_range(255), pick_value()));
      else
        send_item(random_query());
    end
  endtask

  always @(negedge clk)
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %p", rsp_ch.data);
      end else begin
        want = answers_due.pop_front();
        if (rsp_ch.data.kth_value !== want.kth_value ||
            rsp_ch.data.match_count !== want.match_count ||
            rsp_ch.data.winner !== want.winner ||
            rsp_ch.data.query_error !== want.query_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, rsp_ch.data);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    mismatches = 0;
    element_limit = 9'd256;
    send_idle_pct = 29;
    recv_stall_pct = 59;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_preload();
    test_directed();
    test_random(160, 29, 59, 9'd256);
    test_random(160, 59, 29, 9'd200);
    test_random(150, 0, 0, 9'd300);
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
design/rkq_pkg.sv
design/rkq_if.sv
design/rkq_ram.sv
design/rkq_datapath.sv
design/rkq_ctrl.sv
design/range_kth_smallest_query.sv
tb/rkq_tb_if.sv
tb/range_kth_smallest_query_tb.sv
